// ----- rtl/hvr_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// hvr_pkg - shared types and constants of the heading vector rotator
// Field widths, pipeline data layout, yaw source codes and the CORDIC
// arctangent table.
// ---------------------------------------------------------------------------
package hvr_pkg;

   localparam int VECTOR_WIDTH  = 16;
   localparam int ANGLE_WIDTH   = 16;
   localparam int CORDIC_STAGES = 16;

   // the arctangent table has 32 entries, so at most 32 cells
   localparam int STAGE_COUNT = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
   localparam int STAGE_IDX_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;

   localparam int GUARD_BITS = 16;
   // prescaled vector keeps guard bits plus headroom for CORDIC gain and sqrt(2)
   localparam int DATA_W     = VECTOR_WIDTH + GUARD_BITS + 2;
   localparam int ZW         = 33;
   localparam int GAIN_W     = 33;
   localparam int PROD_W     = VECTOR_WIDTH + GAIN_W;
   localparam int PRE_SHIFT  = 32 - GUARD_BITS;

   // limiting CORDIC inverse gain, Q0.32
   localparam logic signed [GAIN_W-1:0] INV_GAIN     = 33'sd2608131496;
   localparam logic signed [ZW-1:0]     QUARTER_TURN = 33'sd1073741824;

   localparam logic [1:0] SRC_NONE   = 2'd0;
   localparam logic [1:0] SRC_HEAD   = 2'd1;
   localparam logic [1:0] SRC_FIRST  = 2'd2;
   localparam logic [1:0] SRC_SECOND = 2'd3;

   // top two bits of the 32-bit binary angle
   localparam logic [1:0] QUAD_PLUS  = 2'b01;
   localparam logic [1:0] QUAD_MINUS = 2'b10;

   localparam logic REG_MOVEMENT_SOURCE = 1'b0;
   localparam logic REG_BODY_FOLLOW     = 1'b1;

   typedef struct packed {
      logic signed [VECTOR_WIDTH-1:0] move_x;
      logic signed [VECTOR_WIDTH-1:0] move_y;
      logic signed [ANGLE_WIDTH-1:0]  head_yaw;
      logic signed [ANGLE_WIDTH-1:0]  first_hand_yaw;
      logic signed [ANGLE_WIDTH-1:0]  second_hand_yaw;
      logic signed [ANGLE_WIDTH-1:0]  realign_yaw;
      logic                           aiming;
      logic                           weapon_equipped;
      logic                           menu_active;
   } hvr_req_type;

   typedef struct packed {
      logic signed [VECTOR_WIDTH-1:0] out_x;
      logic signed [VECTOR_WIDTH-1:0] out_y;
      logic                           was_rotated;
   } hvr_rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]       x;
      logic signed [DATA_W-1:0]       y;
      logic signed [ZW-1:0]           z;
      logic                           bypass;
      logic signed [VECTOR_WIDTH-1:0] raw_x;
      logic signed [VECTOR_WIDTH-1:0] raw_y;
   } hvr_stage_type;

   function automatic logic [31:0] atan_at(input logic [4:0] idx);
      logic [31:0] val;
      unique case (idx)
         5'd0:    val = 32'h20000000;
         5'd1:    val = 32'h12E4051D;
         5'd2:    val = 32'h09FB385B;
         5'd3:    val = 32'h051111D4;
         5'd4:    val = 32'h028B0D43;
         5'd5:    val = 32'h0145D7E1;
         5'd6:    val = 32'h00A2F61E;
         5'd7:    val = 32'h00517C55;
         5'd8:    val = 32'h0028BE53;
         5'd9:    val = 32'h00145F2E;
         5'd10:   val = 32'h000A2F98;
         5'd11:   val = 32'h000517CC;
         5'd12:   val = 32'h00028BE6;
         5'd13:   val = 32'h000145F3;
         5'd14:   val = 32'h0000A2F9;
         5'd15:   val = 32'h0000517C;
         5'd16:   val = 32'h000028BE;
         5'd17:   val = 32'h0000145F;
         5'd18:   val = 32'h00000A2F;
         5'd19:   val = 32'h00000517;
         5'd20:   val = 32'h0000028B;
         5'd21:   val = 32'h00000145;
         5'd22:   val = 32'h000000A2;
         5'd23:   val = 32'h00000051;
         5'd24:   val = 32'h00000028;
         5'd25:   val = 32'h00000014;
         5'd26:   val = 32'h0000000A;
         5'd27:   val = 32'h00000005;
         5'd28:   val = 32'h00000002;
         5'd29:   val = 32'h00000001;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/hvr_prep.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// hvr_prep - yaw selection, gain prescale and quadrant step
// Two pipeline stages ahead of the CORDIC cells: the first picks the yaw
// source and multiplies by the inverse gain, the second folds the angle
// into [-90, 90) degrees.
// ---------------------------------------------------------------------------
module hvr_prep import hvr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic          in_valid,
   input  wire hvr_req_type   in_data,
   input  wire logic [1:0]    movement_source,
   input  wire logic          body_follow,
   output logic               out_valid,
   output hvr_stage_type      out_stage
);

   logic [1:0]                  src;
   logic [ANGLE_WIDTH-1:0]      yaw;
   logic [ANGLE_WIDTH-1:0]      angle;
   logic [31:0]                 a32;
   logic signed [PROD_W-1:0]    prod_x;
   logic signed [PROD_W-1:0]    prod_y;
   hvr_stage_type               s1_in;
   hvr_stage_type               s1_ff;
   logic                        s1_valid_ff;
   hvr_stage_type               s2_in;
   hvr_stage_type               s2_ff;
   logic                        s2_valid_ff;

   always_comb begin
      src = movement_source;
      if (body_follow) begin
         if (in_data.aiming || in_data.weapon_equipped || (src == SRC_NONE)) begin
            src = SRC_HEAD;
         end
      end
      unique case (src)
         SRC_HEAD:   yaw = in_data.head_yaw;
         SRC_FIRST:  yaw = in_data.first_hand_yaw;
         SRC_SECOND: yaw = in_data.second_hand_yaw;
         default:    yaw = in_data.head_yaw;
      endcase
   end

   assign angle  = yaw - in_data.realign_yaw;
   assign a32    = 32'(angle) << (32 - ANGLE_WIDTH);
   assign prod_x = in_data.move_x * INV_GAIN;
   assign prod_y = in_data.move_y * INV_GAIN;

   always_comb begin
      s1_in.x      = DATA_W'(prod_x >>> PRE_SHIFT);
      s1_in.y      = DATA_W'(prod_y >>> PRE_SHIFT);
      s1_in.z      = ZW'($signed(a32));
      s1_in.bypass = (src == SRC_NONE) || in_data.menu_active
                     || ((in_data.move_x == '0) && (in_data.move_y == '0));
      s1_in.raw_x  = in_data.move_x;
      s1_in.raw_y  = in_data.move_y;
   end

   // pre-rotate by a quarter turn so the residual lies in [-90, 90)
   always_comb begin
      s2_in = s1_ff;
      unique case (s1_ff.z[31:30])
         QUAD_PLUS: begin
            s2_in.x = -s1_ff.y;
            s2_in.y = s1_ff.x;
            s2_in.z = s1_ff.z - QUARTER_TURN;
         end
         QUAD_MINUS: begin
            s2_in.x = s1_ff.y;
            s2_in.y = -s1_ff.x;
            s2_in.z = s1_ff.z + QUARTER_TURN;
         end
         default: begin
            s2_in = s1_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_stage = s2_ff;

endmodule
`default_nettype wire

// ----- rtl/hvr_cell.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// hvr_cell - one CORDIC micro-rotation
// Rotates the vector by plus or minus atan(2^-i) toward a zero residual
// angle and hands the result to the next cell.
// ---------------------------------------------------------------------------
module hvr_cell import hvr_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic [STAGE_IDX_W-1:0] stage_idx,
   input  wire logic                   in_valid,
   input  wire hvr_stage_type          in_stage,
   output logic                        out_valid,
   output hvr_stage_type               out_stage
);

   logic signed [DATA_W-1:0] dx;
   logic signed [DATA_W-1:0] dy;
   logic signed [ZW-1:0]     step_angle;
   hvr_stage_type            stage_in;
   hvr_stage_type            stage_ff;
   logic                     valid_ff;

   assign dx         = in_stage.y >>> stage_idx;
   assign dy         = in_stage.x >>> stage_idx;
   assign step_angle = ZW'(atan_at(5'(stage_idx)));

   always_comb begin
      stage_in = in_stage;
      if (!in_stage.z[ZW-1]) begin
         stage_in.x = in_stage.x - dx;
         stage_in.y = in_stage.y + dy;
         stage_in.z = in_stage.z - step_angle;
      end else begin
         stage_in.x = in_stage.x + dx;
         stage_in.y = in_stage.y - dy;
         stage_in.z = in_stage.z + step_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule
`default_nettype wire

// ----- rtl/heading_vector_rotator.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// heading_vector_rotator - rotates a move vector by the chosen yaw
// Pipelined CORDIC rotation of a Q1.15 vector with rounding and saturation.
// ---------------------------------------------------------------------------
// The block takes one item per cycle and delivers one result per item, in
// order. Its stages are two preparation stages (yaw select with gain
// multiply, quadrant step), one CORDIC cell per stage, and the rounding
// output register. The whole pipeline holds while a result waits on
// rsp_ready. The yaw source and the follow-body flag sit in two registers
// at byte addresses 0 and 4.
module heading_vector_rotator import hvr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire hvr_req_type   req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output hvr_rsp_type        rsp_data,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [2:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam logic signed [DATA_W:0] ROUND_HALF = (DATA_W+1)'(64'sd1 <<< (GUARD_BITS - 1));
   localparam logic signed [DATA_W:0] VEC_MAX    =
      (DATA_W+1)'((64'sd1 <<< (VECTOR_WIDTH - 1)) - 64'sd1);
   localparam logic signed [DATA_W:0] VEC_MIN    = -VEC_MAX - (DATA_W+1)'(1);

   logic [1:0]          movement_source_ff;
   logic                body_follow_ff;
   logic                csr_write;
   logic                advance;
   logic                chain_valid [0:STAGE_COUNT];
   hvr_stage_type       chain_stage [0:STAGE_COUNT];
   hvr_stage_type       last_stage;
   hvr_rsp_type         rsp_in;
   hvr_rsp_type         rsp_data_ff;
   logic                rsp_valid_ff;

   function automatic logic signed [VECTOR_WIDTH-1:0] round_sat(
      input logic signed [DATA_W-1:0] v
   );
      logic signed [DATA_W:0] r;
      logic signed [VECTOR_WIDTH-1:0] res;
      r = ((DATA_W+1)'(v) + ROUND_HALF) >>> GUARD_BITS;
      if (r > VEC_MAX) begin
         res = VEC_MAX[VECTOR_WIDTH-1:0];
      end else if (r < VEC_MIN) begin
         res = VEC_MIN[VECTOR_WIDTH-1:0];
      end else begin
         res = r[VECTOR_WIDTH-1:0];
      end
      return res;
   endfunction

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         movement_source_ff <= SRC_NONE;
         body_follow_ff     <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_MOVEMENT_SOURCE: movement_source_ff <= csr_pwdata[1:0];
            REG_BODY_FOLLOW:     body_follow_ff     <= csr_pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_MOVEMENT_SOURCE: csr_prdata = 32'(movement_source_ff);
         REG_BODY_FOLLOW:     csr_prdata = 32'(body_follow_ff);
      endcase
   end

   // advance the whole pipeline unless a result is held back
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   hvr_prep u_prep (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .in_valid        (req_valid),
      .in_data         (req_data),
      .movement_source (movement_source_ff),
      .body_follow     (body_follow_ff),
      .out_valid       (chain_valid[0]),
      .out_stage       (chain_stage[0])
   );

   for (genvar g = 0; g < STAGE_COUNT; g++) begin : g_cell
      hvr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_idx (STAGE_IDX_W'(g)),
         .in_valid  (chain_valid[g]),
         .in_stage  (chain_stage[g]),
         .out_valid (chain_valid[g+1]),
         .out_stage (chain_stage[g+1])
      );
   end

   assign last_stage = chain_stage[STAGE_COUNT];

   always_comb begin
      if (last_stage.bypass) begin
         rsp_in.out_x       = last_stage.raw_x;
         rsp_in.out_y       = last_stage.raw_y;
         rsp_in.was_rotated = 1'b0;
      end else begin
         rsp_in.out_x       = round_sat(last_stage.x);
         rsp_in.out_y       = round_sat(last_stage.y);
         rsp_in.was_rotated = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain_valid[STAGE_COUNT];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !chain_valid[0])
      else $error("pipeline valid not cleared by reset");

   a_quadrant_range: assert property (@(posedge clock) disable iff (reset)
      chain_valid[0] && !chain_stage[0].bypass |->
         (chain_stage[0].z >= -QUARTER_TURN) && (chain_stage[0].z < QUARTER_TURN))
      else $error("residual angle outside half turn after quadrant step");

   a_residual_converged: assert property (@(posedge clock) disable iff (reset)
      chain_valid[STAGE_COUNT] && !last_stage.bypass |->
         (last_stage.z >= -QUARTER_TURN) && (last_stage.z <= QUARTER_TURN))
      else $error("CORDIC residual diverged");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(chain_valid[STAGE_COUNT]) && $stable(last_stage))
      else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire
